FILE: rtl/core/spq_pkg.sv
// spq_pkg: types and fixed constants for the sorted priority queue
// shared by spq_cell and sorted_priority_queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   // field widths of the request and response words
   localparam int KEY_W   = 16;
   localparam int VALUE_W = 32;
   localparam int FILL_W  = 4;
   localparam int STAT_W  = 2;

   // action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   // request word
   typedef struct packed {
      logic                      action;
      logic signed [VALUE_W-1:0] item_value;
      logic        [KEY_W-1:0]   item_key;
   } req_word_type;

   // response word
   typedef struct packed {
      logic        [STAT_W-1:0]  status;
      logic signed [VALUE_W-1:0] out_value;
      logic        [KEY_W-1:0]   out_key;
      logic        [FILL_W-1:0]  fill_level;
   } rsp_word_type;

   // one stored entry, passed between neighboring cells
   typedef struct packed {
      logic        [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic                      ins;
      logic                      rem;
      logic        [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// spq_cell: one slot of the sorted queue, holds a key and value
// depends on spq_pkg for the entry and control structs
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  wire logic                   clock,
   input  wire logic                   occ,
   input  wire spq_pkg::cell_ctrl_type ctrl,
   input  wire spq_pkg::entry_type     left,
   input  wire logic                   left_sel,
   input  wire spq_pkg::entry_type     right,
   output spq_pkg::entry_type          held,
   output logic                        sel
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // slot is at or behind the insert point: empty or key not smaller
   assign sel  = !occ || (entry_ff.key >= ctrl.key);
   assign held = entry_ff;

   // shift back on insert, forward on remove
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (left_sel) begin
            entry_in = left;
         end else if (sel) begin
            entry_in.key   = ctrl.key;
            entry_in.value = ctrl.value;
         end
      end else if (ctrl.rem) begin
         entry_in = right;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue.sv
// sorted_priority_queue: the response is valid in the cycle after request accept.
// throughput is one word per cycle while rsp_ready is high; every cell compares
// its key with the new key in parallel, so insert and remove each finish in the
// accepting cycle. reset clears the fill count and the response valid flag; stored
// entries and the response word are left undefined and are never read until written.
// depends on spq_pkg and spq_cell
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
   parameter int DEPTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire spq_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output spq_pkg::rsp_word_type      rsp_word
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   spq_pkg::rsp_word_type  rsp_ff;
   spq_pkg::rsp_word_type  rsp_in;

   logic                   accept;
   logic                   full;
   logic                   empty;
   spq_pkg::cell_ctrl_type ctrl;
   logic [DEPTH-1:0]       occ;
   logic [DEPTH-1:0]       sel;
   spq_pkg::entry_type     held [DEPTH];

   // handshake: take a word whenever the response register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // operation sent down the row
   assign ctrl.ins   = accept && (req_word.action == spq_pkg::ACT_INSERT) && !full;
   assign ctrl.rem   = accept && (req_word.action == spq_pkg::ACT_REMOVE) && !empty;
   assign ctrl.key   = req_word.item_key;
   assign ctrl.value = req_word.item_value;

   // row of cells, front at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_e;
      spq_pkg::entry_type right_e;
      logic               left_s;

      assign occ[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_s = 1'b0;
      end else begin : g_mid
         assign left_e = held[i-1];
         assign left_s = sel[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = held[i+1];
      end

      spq_cell u_cell (
         .clock    (clock),
         .occ      (occ[i]),
         .ctrl     (ctrl),
         .left     (left_e),
         .left_sel (left_s),
         .right    (right_e),
         .held     (held[i]),
         .sel      (sel[i])
      );
   end

   // fill count and response word
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.rem) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = spq_pkg::ST_DONE;
         rsp_in.out_value   = '0;
         rsp_in.out_key     = '0;
         rsp_in.fill_level  = spq_pkg::FILL_W'(count_in);
         if (req_word.action == spq_pkg::ACT_INSERT) begin
            if (full) begin
               rsp_in.status = spq_pkg::ST_FULL;
            end
         end else begin
            if (empty) begin
               rsp_in.status = spq_pkg::ST_EMPTY;
            end else begin
               rsp_in.out_value = held[0].value;
               rsp_in.out_key   = held[0].key;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // fill count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   // an accepted insert into a non-full queue grows the count by one
   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("insert did not grow fill count");

   // a successful remove reports the front entry seen at accept
   a_rem_front: assert property (@(posedge clock) disable iff (reset)
      ctrl.rem |=> rsp_ff.out_key == $past(held[0].key) &&
                   rsp_ff.out_value == $past(held[0].value))
      else $error("remove did not return front entry");

   // the two front entries stay in key order
   a_front_order: assert property (@(posedge clock) disable iff (reset)
      occ[1] |-> held[0].key <= held[1].key)
      else $error("front entries out of key order");
`endif

endmodule

`default_nettype wire

FILE: tb/spq_order_checker.sv
// spq_order_checker: watches both channels of sorted_priority_queue, keeps its own
// key-ordered copy of the stored entries and compares every response word
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_order_checker #(
   parameter int DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  spq_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  spq_pkg::rsp_word_type rsp_word,
   output int                    fail_count,
   output int                    words_owed
);

   // shadow copy of the sorted entries, index 0 is the front
   logic        [spq_pkg::KEY_W-1:0]   shadow_keys [DEPTH];
   logic signed [spq_pkg::VALUE_W-1:0] shadow_values [DEPTH];
   int                                 shadow_fill = 0;

   // response words still to come, oldest first
   spq_pkg::rsp_word_type due_responses [$];
   int                    mismatches = 0;

   // apply one request word to the shadow queue and build its response
   function automatic spq_pkg::rsp_word_type queue_step(input spq_pkg::req_word_type w);
      spq_pkg::rsp_word_type r;
      int                    pos;
      r = '0;
      r.status = spq_pkg::ST_DONE;
      if (w.action == spq_pkg::ACT_INSERT) begin
         if (shadow_fill >= DEPTH) begin
            r.status = spq_pkg::ST_FULL;
         end else begin
            // new entry goes ahead of every equal or greater key
            pos = shadow_fill;
            while (pos > 0 && shadow_keys[pos-1] >= w.item_key) begin
               shadow_keys[pos]   = shadow_keys[pos-1];
               shadow_values[pos] = shadow_values[pos-1];
               pos--;
            end
            shadow_keys[pos]   = w.item_key;
            shadow_values[pos] = w.item_value;
            shadow_fill++;
         end
      end else begin
         if (shadow_fill == 0) begin
            r.status = spq_pkg::ST_EMPTY;
         end else begin
            r.out_value = shadow_values[0];
            r.out_key   = shadow_keys[0];
            for (pos = 1; pos < shadow_fill; pos++) begin
               shadow_keys[pos-1]   = shadow_keys[pos];
               shadow_values[pos-1] = shadow_values[pos];
            end
            shadow_fill--;
         end
      end
      r.fill_level = spq_pkg::FILL_W'(shadow_fill);
      return r;
   endfunction

   // response first, then the request accepted at the same edge
   always @(posedge clock) begin
      spq_pkg::rsp_word_type want;
      if (reset) begin
         due_responses.delete();
         shadow_fill = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response status=%0d value=%0d key=%h fill=%0d",
                           $time, rsp_word.status, rsp_word.out_value,
                           rsp_word.out_key, rsp_word.fill_level);
            end else begin
               want = due_responses.pop_front();
               if (rsp_word.status !== want.status || rsp_word.out_value !== want.out_value ||
                   rsp_word.out_key !== want.out_key ||
                   rsp_word.fill_level !== want.fill_level) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch expected status=%0d value=%0d key=%h fill=%0d",
                              $time, want.status, want.out_value, want.out_key,
                              want.fill_level,
                              " got status=%0d value=%0d key=%h fill=%0d",
                              rsp_word.status, rsp_word.out_value, rsp_word.out_key,
                              rsp_word.fill_level);
               end
            end
         end
         if (req_valid && req_ready)
            due_responses.push_back(queue_step(req_word));
      end
      words_owed <= due_responses.size();
      fail_count <= mismatches;
   end

endmodule

FILE: tb/sorted_priority_queue_tb.sv
// sorted_priority_queue_tb: drives request words into sorted_priority_queue with
// random gaps and response stalls; spq_order_checker does all the checking
// depends on spq_pkg, sorted_priority_queue and spq_order_checker
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

   localparam int DEPTH        = 8;
   localparam int RANDOM_WORDS = 930;
   localparam int CALM_FROM    = 780;
   localparam int PRESSURE_AT  = 300;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  rsp_ready = 1'b0;
   spq_pkg::req_word_type req_word  = '0;
   logic                  req_ready;
   logic                  rsp_valid;
   spq_pkg::rsp_word_type rsp_word;
   int                    fail_count;
   int                    words_owed;
   int                    holds_wanted = 0;
   bit                    calm = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   sorted_priority_queue #(.DEPTH(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   spq_order_checker #(.DEPTH(DEPTH)) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .words_owed (words_owed)
   );

   function automatic spq_pkg::req_word_type make_req(
      input logic                          act,
      input logic [spq_pkg::VALUE_W-1:0]   v,
      input logic [spq_pkg::KEY_W-1:0]     k);
      spq_pkg::req_word_type w;
      w.action     = act;
      w.item_value = v;
      w.item_key   = k;
      return w;
   endfunction

   // keys: many ties, the extremes, and the full range
   function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return spq_pkg::KEY_W'($urandom_range(0, 3));
         1: return $urandom_range(0, 1) ? '1 : '0;
         default: return spq_pkg::KEY_W'($urandom);
      endcase
   endfunction

   // offer one word and hold it until accepted
   task automatic send_word(input spq_pkg::req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // random sender gap between words
   task automatic maybe_pause();
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side: random stall bursts plus one long hold-off on request
   initial begin
      int holds_served;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (holds_served < holds_wanted) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (80) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // stimulus and verdict
   initial begin
      int n;
      int ins_pct;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty remove, extremes, ties, full refusal, drain past empty
      send_word(make_req(spq_pkg::ACT_REMOVE, $urandom, spq_pkg::KEY_W'($urandom)));
      maybe_pause();
      send_word(make_req(spq_pkg::ACT_INSERT, 32'h7FFF_FFFF, 16'hFFFF));
      send_word(make_req(spq_pkg::ACT_INSERT, 32'h8000_0000, 16'h0000));
      maybe_pause();
      send_word(make_req(spq_pkg::ACT_INSERT, 32'h0000_0000, 16'h8000));
      send_word(make_req(spq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 16'h8000));
      send_word(make_req(spq_pkg::ACT_INSERT, 32'h5555_AAAA, 16'h8000));
      maybe_pause();
      send_word(make_req(spq_pkg::ACT_INSERT, 32'hAAAA_5555, 16'hFFFF));
      send_word(make_req(spq_pkg::ACT_INSERT, 32'h0000_0001, 16'h0000));
      send_word(make_req(spq_pkg::ACT_INSERT, 32'h0000_0002, 16'h7FFF));
      send_word(make_req(spq_pkg::ACT_INSERT, 32'h0000_0003, 16'h0001));
      maybe_pause();
      send_word(make_req(spq_pkg::ACT_INSERT, 32'h0000_0004, 16'h0000));
      for (n = 0; n < DEPTH + 1; n++) begin
         send_word(make_req(spq_pkg::ACT_REMOVE, $urandom, spq_pkg::KEY_W'($urandom)));
         maybe_pause();
      end

      // random: fill level swept by cycling insert-heavy, remove-heavy and balanced runs
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n == CALM_FROM)
            calm = 1'b1;
         if (n == PRESSURE_AT) begin
            // receiver holds off while inserts keep coming, so the input stalls
            holds_wanted++;
            repeat (20) send_word(make_req(spq_pkg::ACT_INSERT, $urandom, pick_key()));
            n += 20;
         end
         case ((n / 40) % 3)
            0: ins_pct = 75;
            1: ins_pct = 25;
            default: ins_pct = 50;
         endcase
         if ($urandom_range(1, 100) <= ins_pct)
            send_word(make_req(spq_pkg::ACT_INSERT, $urandom, pick_key()));
         else
            send_word(make_req(spq_pkg::ACT_REMOVE, $urandom, spq_pkg::KEY_W'($urandom)));
         maybe_pause();
      end
      req_valid <= 1'b0;

      // drain then settle
      while (words_owed != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (fail_count == 0 && words_owed == 0)
         $display("sorted_priority_queue_tb OK");
      else
         $display("sorted_priority_queue_tb NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("sorted_priority_queue_tb NOT OK");
      $finish;
   end

endmodule
